[rtl/core/wfc_pkg.sv]
package wfc_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned MaxWordBytes = 64;
  localparam int unsigned CountBits    = 32;

  localparam int unsigned IndexBits = 10;
  localparam int unsigned OutCountBits = 32;

  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChPeriod   = 8'h2E;
  localparam logic [7:0] ChBang     = 8'h21;
  localparam logic [7:0] ChNewline  = 8'h0A;
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChSemi     = 8'h3B;
  localparam logic [7:0] ChColon    = 8'h3A;
  localparam logic [7:0] ChUpperA   = 8'h41;
  localparam logic [7:0] ChUpperZ   = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'd32;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [IndexBits-1:0]    entry_index;
    logic [OutCountBits-1:0] word_count;
    logic                    is_new;
    logic                    table_full;
    logic                    word_too_long;
  } out_item_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == ChSpace) || (c == ChPeriod) || (c == ChBang) || (c == ChNewline) ||
           (c == ChComma) || (c == ChQuestion) || (c == ChSemi) || (c == ChColon);
  endfunction

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return ((c >= ChUpperA) && (c <= ChUpperZ)) ? c + CaseOffset : c;
  endfunction

endpackage

[rtl/core/wfc_in_if.sv]
interface wfc_in_if;
  logic               valid;
  logic               ready;
  wfc_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/wfc_out_if.sv]
interface wfc_out_if;
  logic               valid;
  logic               ready;
  wfc_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/wfc_ram.sv]
module wfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/word_frequency_counter.sv]
// Channel | Dir | Payload                                              | Accept
// in_i    | in  | text_byte[7:0], end_of_text                          | valid & ready
// out_o   | out | entry_index, word_count, is_new, table_full, too_long | valid & ready
//
// A word byte is stored while idle. A delimiter ending a word walks the table one
// entry at a time through the shared byte compare: each entry's length is read
// and checked, then its bytes are compared in turn when the lengths agree. A
// miss appends the word, copying len bytes from the word buffer into the table,
// or reports table_full when no entry is free; a hit reads the entry's count
// and writes it back incremented, saturating at its maximum.
// rst_ni clears the entry count and the word length; the stores need no clear.
// The input is not ready while a lookup runs or while a result waits.
module word_frequency_counter #(
  parameter int unsigned TableEntries = wfc_pkg::TableEntries,
  parameter int unsigned MaxWordBytes = wfc_pkg::MaxWordBytes,
  parameter int unsigned CountBits    = wfc_pkg::CountBits
) (
  input logic     clk_i,
  input logic     rst_ni,
  wfc_in_if.sink    in_i,
  wfc_out_if.source out_o
);

  localparam int unsigned EB = $clog2(TableEntries);
  localparam int unsigned WB = $clog2(MaxWordBytes);
  localparam int unsigned LB = $clog2(MaxWordBytes + 1);
  localparam int unsigned UB = $clog2(TableEntries + 1);
  localparam int unsigned CB = EB + WB;
  localparam int unsigned IB = wfc_pkg::IndexBits;
  localparam int unsigned OB = wfc_pkg::OutCountBits;
  localparam logic [CountBits-1:0] CountMax = '1;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StLenRd  = 3'd1;
  localparam logic [2:0] StLenChk = 3'd2;
  localparam logic [2:0] StCmp    = 3'd3;
  localparam logic [2:0] StCntRd  = 3'd4;
  localparam logic [2:0] StCntUpd = 3'd5;
  localparam logic [2:0] StCopy   = 3'd6;
  localparam logic [2:0] StOut    = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [LB-1:0] cur_len_q, cur_len_d;
  logic          ovf_q, ovf_d;
  logic [UB-1:0] used_q, used_d;
  logic [EB-1:0] ent_q, ent_d;
  logic [LB-1:0] pos_q, pos_d;
  logic          mismatch_q, mismatch_d;
  wfc_pkg::out_item_t res_q, res_d;

  // Current-word buffer: small RAM, written by the input and read by the walk.
  logic          wb_we;
  logic [WB-1:0] wb_waddr, wb_raddr;
  logic [7:0]    wb_wdata, wb_rdata;

  // Table stores.
  logic            ch_we, len_we, cnt_we;
  logic [CB-1:0]   ch_waddr, ch_raddr;
  logic [7:0]      ch_rdata;
  logic [LB-1:0]   len_rdata;
  logic [CountBits-1:0] cnt_wdata, cnt_rdata;
  logic [EB-1:0]   tab_waddr;

  wfc_ram #(.Width(8), .Depth(MaxWordBytes)) u_word (
    .clk_i, .we_i(wb_we), .waddr_i(wb_waddr), .wdata_i(wb_wdata),
    .raddr_i(wb_raddr), .rdata_o(wb_rdata));
  wfc_ram #(.Width(8), .Depth(TableEntries * MaxWordBytes)) u_chars (
    .clk_i, .we_i(ch_we), .waddr_i(ch_waddr), .wdata_i(wb_rdata),
    .raddr_i(ch_raddr), .rdata_o(ch_rdata));
  wfc_ram #(.Width(LB), .Depth(TableEntries)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(tab_waddr), .wdata_i(cur_len_q),
    .raddr_i(ent_q), .rdata_o(len_rdata));
  wfc_ram #(.Width(CountBits), .Depth(TableEntries)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(tab_waddr), .wdata_i(cnt_wdata),
    .raddr_i(ent_q), .rdata_o(cnt_rdata));

  logic in_fire, c_delim, last_ent, pos_last;
  logic [7:0] c_in;

  assign in_i.ready    = (state_q == StIdle);
  assign in_fire       = in_i.valid && in_i.ready;
  assign c_in          = in_i.payload.text_byte;
  assign c_delim       = wfc_pkg::is_delim(c_in);
  assign out_o.valid   = (state_q == StOut);
  assign out_o.payload = res_q;
  assign last_ent      = ({{(UB-EB){1'b0}}, ent_q} + UB'(1)) >= used_q;
  assign pos_last      = (pos_q + LB'(1)) >= cur_len_q;

  assign wb_we    = in_fire && !c_delim && (cur_len_q < LB'(MaxWordBytes));
  assign wb_waddr = cur_len_q[WB-1:0];
  assign wb_wdata = wfc_pkg::fold_lower(c_in);
  assign wb_raddr = pos_d[WB-1:0];
  assign ch_raddr = {ent_d, pos_d[WB-1:0]};
  assign tab_waddr = ent_q;

  // Sequencer: read length, compare bytes one per cycle, then update or append.
  always_comb begin
    state_d = state_q; cur_len_d = cur_len_q; ovf_d = ovf_q; used_d = used_q;
    ent_d = ent_q; pos_d = pos_q; mismatch_d = mismatch_q; res_d = res_q;
    ch_we = 1'b0; len_we = 1'b0; cnt_we = 1'b0;
    ch_waddr = {ent_q, pos_q[WB-1:0]};
    cnt_wdata = cnt_rdata;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (c_delim) begin
            res_d.word_too_long = ovf_q;
            res_d.is_new = 1'b0; res_d.table_full = 1'b0;
            ent_d = '0; pos_d = '0;
            if (cur_len_q != '0) begin
              if (used_q == '0) begin
                state_d = (used_q < UB'(TableEntries)) ? StCopy : StOut;
              end else begin
                state_d = StLenRd;
              end
            end
            ovf_d = 1'b0;
            if (cur_len_q == '0) cur_len_d = '0;
          end else begin
            if (cur_len_q < LB'(MaxWordBytes)) cur_len_d = cur_len_q + LB'(1);
            else ovf_d = 1'b1;
          end
          // End of text clears only after a finished word has been captured.
          if (in_i.payload.end_of_text && !(c_delim && cur_len_q != '0)) begin
            cur_len_d = '0; ovf_d = 1'b0;
          end
        end
      end
      StLenRd: state_d = StLenChk;
      StLenChk: begin
        mismatch_d = 1'b0;
        if (len_rdata == cur_len_q) begin
          state_d = StCmp;
        end else if (last_ent) begin
          ent_d = used_q[EB-1:0]; pos_d = '0;
          state_d = (used_q < UB'(TableEntries)) ? StCopy : StOut;
          res_d.table_full = !(used_q < UB'(TableEntries));
        end else begin
          ent_d = ent_q + EB'(1); state_d = StLenRd;
        end
      end
      StCmp: begin
        if (ch_rdata != wb_rdata) mismatch_d = 1'b1;
        if (!pos_last && ch_rdata == wb_rdata) begin
          pos_d = pos_q + LB'(1);
        end else if (!mismatch_d) begin
          state_d = StCntRd;
        end else if (last_ent) begin
          ent_d = used_q[EB-1:0]; pos_d = '0;
          state_d = (used_q < UB'(TableEntries)) ? StCopy : StOut;
          res_d.table_full = !(used_q < UB'(TableEntries));
        end else begin
          ent_d = ent_q + EB'(1); pos_d = '0; state_d = StLenRd;
        end
      end
      StCntRd: state_d = StCntUpd;
      StCntUpd: begin
        cnt_wdata = (cnt_rdata != CountMax) ? cnt_rdata + CountBits'(1) : cnt_rdata;
        cnt_we = 1'b1;
        res_d.entry_index = IB'(ent_q);
        res_d.word_count  = OB'(cnt_wdata);
        state_d = StOut;
      end
      StCopy: begin
        // Byte pos_q is on the word buffer's read port this cycle.
        ch_we = 1'b1;
        pos_d = pos_q + LB'(1);
        if (pos_last) begin
          len_we = 1'b1; cnt_we = 1'b1; cnt_wdata = CountBits'(1);
          used_d = used_q + UB'(1);
          res_d.entry_index = IB'(ent_q);
          res_d.word_count = OB'(1);
          res_d.is_new = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        if (res_q.table_full) begin
          res_d.entry_index = '0; res_d.word_count = '0;
        end
        if (out_o.ready) begin
          state_d = StIdle; cur_len_d = '0; ovf_d = 1'b0;
        end
      end
      default: state_d = StIdle;
    endcase
    if (state_q != StOut && state_d == StOut && res_d.table_full) begin
      res_d.entry_index = '0; res_d.word_count = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cur_len_q <= '0; ovf_q <= 1'b0; used_q <= '0;
    end else begin
      state_q <= state_d; cur_len_q <= cur_len_d; ovf_q <= ovf_d; used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d; pos_q <= pos_d; mismatch_q <= mismatch_d; res_q <= res_d;
  end

endmodule
